// File: hw/rtl/arkg_pkg.sv
`default_nettype none

package arkg_pkg;

  // Default build values
  localparam int unsigned LEVEL_COUNT_DEF = 7;
  localparam int unsigned ADC_BITS_DEF    = 12;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 4;   // holds any level up to sixteen levels
  localparam int unsigned CD_W     = 9;
  localparam int unsigned ALIVE_W  = 8;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [ALIVE_W-1:0] ALIVE_MAX_RST = 8'd15;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CD_W-1:0]      countdown_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;

  typedef struct packed {
    logic                keepalive_fire;
    logic                led_lit;
    logic [2:0]          level_now;
    logic [ALIVE_W-1:0]  alive_value;
  } result_t;

  // Keepalive period per level; levels past six repeat the fastest entry
  function automatic countdown_t ka_period(input level_t lvl);
    countdown_t p;
    unique case (lvl)
      4'd0:    p = 9'd500;
      4'd1:    p = 9'd200;
      4'd2:    p = 9'd100;
      4'd3:    p = 9'd50;
      4'd4:    p = 9'd20;
      4'd5:    p = 9'd10;
      default: p = 9'd5;
    endcase
    return p;
  endfunction

  // Half of the LED full-cycle period per level
  function automatic elapsed_t led_half(input level_t lvl);
    elapsed_t h;
    unique case (lvl)
      4'd0:    h = 10'd750;
      4'd1:    h = 10'd500;
      4'd2:    h = 10'd400;
      4'd3:    h = 10'd300;
      4'd4:    h = 10'd200;
      4'd5:    h = 10'd150;
      default: h = 10'd100;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/adc_rate_keepalive_generator_top.sv
`default_nettype none
// Keepalive rate generator driven by a potentiometer ADC.
//
// in_*  : one transaction per scheduler tick. in_tuser flags a finished
//         conversion, in_tdata carries the 12-bit sample.
// out_* : exactly one transaction per tick with the keepalive flag, the
//         alive counter, the rate level and the LED drive after that tick.
// cfg_* : writes the largest alive counter value; always ready.
//
// The state advances at the input edge, where the result is registered into
// the output register, or into the skid register while the output stalls. One
// tick is taken every cycle while in_tready is high; the tick update is a single
// pass through small table lookups and counters between the state registers.
// A two-entry output buffer (output register plus skid register) lets a tick
// be taken while a result waits; in_tready drops only while the skid entry is
// full, and rises again once the receiver drains it.
// Reset: level 0, countdown 500, alive counter 0, LED on, alive maximum 15,
// output buffer empty.
module adc_rate_keepalive_generator_top #(
  parameter int unsigned LEVEL_COUNT = arkg_pkg::LEVEL_COUNT_DEF,
  parameter int unsigned ADC_BITS    = arkg_pkg::ADC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] adc_sample, [15:12] zero
  input  wire logic        in_tuser,   // [0] sample_valid

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] alive_value, [10:8] level_now,
                                       // [11] led_lit, [15:12] zero
  output logic             out_tuser,  // [0] keepalive_fire

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data    // alive_counter_max
);

  localparam int unsigned SW = arkg_pkg::SAMPLE_W;
  localparam int unsigned PW = SW + 5;
  localparam logic [SW-1:0] SAMPLE_MASK =
    (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);
  localparam logic [PW-1:0] LEVELS_P = PW'(LEVEL_COUNT);
  localparam arkg_pkg::level_t LEVEL_TOP = arkg_pkg::LEVEL_W'(LEVEL_COUNT - 1);

  arkg_pkg::level_t     rate_level_r, rate_level_nxt;
  arkg_pkg::countdown_t countdown_r, countdown_nxt;
  logic [7:0]           alive_r, alive_nxt;
  logic [7:0]           alive_max_r;
  logic                 led_r, led_nxt;
  arkg_pkg::elapsed_t   elapsed_r, elapsed_nxt;

  logic                 out_valid_r, skid_valid_r;
  arkg_pkg::result_t    out_data_r, skid_data_r, result;

  logic                 in_acc;
  logic [PW-1:0]        product, scaled;
  arkg_pkg::level_t     lvl_map;
  logic                 restart, fire, wrap;
  arkg_pkg::countdown_t cd_a, cd_b;
  arkg_pkg::elapsed_t   el_a;
  logic                 led_a;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Level mapping: (sample * levels) >> ADC_BITS, clamped to the top level
  always_comb begin
    product = PW'(in_tdata[SW-1:0] & SAMPLE_MASK) * LEVELS_P;
    scaled  = product >> ADC_BITS;
    if (scaled >= LEVELS_P) begin
      lvl_map = LEVEL_TOP;
    end else begin
      lvl_map = scaled[arkg_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    restart        = in_tuser && (lvl_map != rate_level_r);
    rate_level_nxt = restart ? lvl_map : rate_level_r;

    cd_a = restart ? arkg_pkg::ka_period(lvl_map) : countdown_r;
    cd_b = (cd_a != '0) ? cd_a - 1'b1 : cd_a;
    fire = (cd_b == '0);
    countdown_nxt = fire ? arkg_pkg::ka_period(rate_level_nxt) : cd_b;

    alive_nxt = alive_r;
    if (fire) begin
      alive_nxt = (alive_r >= alive_max_r) ? 8'd0 : alive_r + 8'd1;
    end

    el_a  = restart ? '0 : elapsed_r + 1'b1;
    led_a = restart ? 1'b1 : led_r;
    wrap  = (el_a >= arkg_pkg::led_half(rate_level_nxt));
    elapsed_nxt = wrap ? '0 : el_a;
    led_nxt     = led_a ^ wrap;

    result.keepalive_fire = fire;
    result.alive_value    = alive_nxt;
    result.level_now      = rate_level_nxt[2:0];
    result.led_lit        = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_level_r <= '0;
      countdown_r  <= arkg_pkg::ka_period('0);
      alive_r      <= '0;
      led_r        <= 1'b1;
      elapsed_r    <= '0;
      alive_max_r  <= arkg_pkg::ALIVE_MAX_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alive_max_r <= cfg_data;
      end
      if (in_acc) begin
        rate_level_r <= rate_level_nxt;
        countdown_r  <= countdown_nxt;
        alive_r      <= alive_nxt;
        led_r        <= led_nxt;
        elapsed_r    <= elapsed_nxt;
      end
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= result;
      end
    end else if (in_acc) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.keepalive_fire;
  assign out_tdata  = {4'd0, out_data_r.led_lit, out_data_r.level_now,
                       out_data_r.alive_value};

  // Skid entry only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    rate_level_r <= LEVEL_TOP)
    else $error("rate level beyond top level");

  // Countdown is reloaded on reaching zero, so it never rests there
  a_countdown_live: assert property (@(posedge clk) disable iff (!rst_n)
    countdown_r != '0)
    else $error("keepalive countdown stuck at zero");

  a_led_phase: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r < arkg_pkg::led_half(rate_level_r))
    else $error("LED phase counter passed half period");

  // A tick taken with room in the output register shows up next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire
